// ===== src/jts_pkg.sv =====
// Shared types and constants for the JSON token scanner.
package jts_pkg;

  // Longest text the offsets are meant to cover; offsets stop at the top value.
  localparam int MAX_TEXT_BYTES = 65536;
  localparam logic [15:0] OFFSET_TOP =
    16'((MAX_TEXT_BYTES - 1 < 65535) ? MAX_TEXT_BYTES - 1 : 65535);

  // One scanned byte produces at most this many tokens.
  localparam int TOKENS_MAX = 3;
  localparam int COUNT_W    = 2;

  // Queue between the scanner and the token serializer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [15:0] offset_t;

  typedef enum logic [3:0] {
    KIND_OBJ_OPEN  = 4'd0,
    KIND_OBJ_CLOSE = 4'd1,
    KIND_ARR_OPEN  = 4'd2,
    KIND_ARR_CLOSE = 4'd3,
    KIND_STRING    = 4'd4,
    KIND_FALSE     = 4'd5,
    KIND_TRUE      = 4'd6,
    KIND_NULL      = 4'd7,
    KIND_NUMBER    = 4'd8,
    KIND_INVALID   = 4'd9,
    KIND_END       = 4'd10
  } token_kind_t;

  typedef struct packed {
    logic        last;
    offset_t     length;
    offset_t     start;
    token_kind_t kind;
  } token_t;

  // All tokens produced by one byte, in output order; count is never zero in the queue.
  typedef struct packed {
    logic [COUNT_W-1:0]        count;
    token_t [TOKENS_MAX-1:0]   tok;
  } bundle_t;

endpackage

// ===== src/jts_front.sv =====
// Byte scanner: holds the lexer state and turns each accepted byte into a token bundle.
module jts_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       text_byte,
  input  logic             end_of_text,
  output logic             push,
  output jts_pkg::bundle_t bundle
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_SKIP
  } mode_t;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_F_UP   = 8'h46;
  localparam logic [7:0] CH_T_LO   = 8'h74;
  localparam logic [7:0] CH_T_UP   = 8'h54;
  localparam logic [7:0] CH_N_LO   = 8'h6E;
  localparam logic [7:0] CH_N_UP   = 8'h4E;

  localparam logic [15:0] LEN_FALSE  = 16'd5;
  localparam logic [15:0] LEN_SHORT  = 16'd4;
  localparam logic [2:0]  SKIP_FALSE = 3'd4;
  localparam logic [2:0]  SKIP_SHORT = 3'd3;

  function automatic jts_pkg::offset_t sat_inc(input jts_pkg::offset_t v);
    return (v >= jts_pkg::OFFSET_TOP) ? jts_pkg::OFFSET_TOP : v + 16'd1;
  endfunction

  function automatic logic is_skip_byte(input logic [7:0] c);
    return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h3A, 8'h2C};
  endfunction

  function automatic logic is_number_start(input logic [7:0] c);
    return c inside {[8'h30:8'h39], 8'h2B, 8'h2D, 8'h2E};
  endfunction

  function automatic logic is_number_body(input logic [7:0] c);
    return is_number_start(c) || c inside {8'h65, 8'h45};
  endfunction

  mode_t           mode, mode_next;
  logic            quote_char, quote_char_next;
  logic            escape_pending, escape_pending_next;
  logic [2:0]      skip_remaining, skip_remaining_next;
  jts_pkg::offset_t token_begin, token_begin_next;
  jts_pkg::offset_t byte_offset, byte_offset_next;

  always_comb begin
    jts_pkg::bundle_t       b;
    logic [jts_pkg::COUNT_W-1:0] cnt;
    jts_pkg::offset_t       p;
    jts_pkg::offset_t       nxt;
    logic [7:0]             quote;
    logic                   do_idle;
    logic [2:0]             skip_dec;

    b                   = '0;
    cnt                 = '0;
    p                   = byte_offset;
    nxt                 = sat_inc(byte_offset);
    quote               = quote_char ? CH_SQUOTE : CH_DQUOTE;
    do_idle             = 1'b0;
    skip_dec            = '0;
    mode_next           = mode;
    quote_char_next     = quote_char;
    escape_pending_next = escape_pending;
    skip_remaining_next = skip_remaining;
    token_begin_next    = token_begin;
    byte_offset_next    = nxt;

    case (mode)
      MODE_STRING: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (text_byte == CH_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (text_byte == quote) begin
          b.tok[cnt] = '{1'b0, p - token_begin, token_begin, jts_pkg::KIND_STRING};
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        // The byte that ends a number is scanned again as a fresh byte.
        if (!is_number_body(text_byte)) begin
          b.tok[cnt] = '{1'b0, p - token_begin, token_begin, jts_pkg::KIND_NUMBER};
          cnt = cnt + 2'd1;
          mode_next = MODE_IDLE;
          do_idle = 1'b1;
        end
      end
      MODE_SKIP: begin
        skip_dec = (skip_remaining != 3'd0) ? skip_remaining - 3'd1 : skip_remaining;
        skip_remaining_next = skip_dec;
        if (skip_dec == 3'd0) begin
          mode_next = MODE_IDLE;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle && !is_skip_byte(text_byte)) begin
      case (text_byte)
        CH_LBRACE: begin
          b.tok[cnt] = '{1'b0, 16'd1, p, jts_pkg::KIND_OBJ_OPEN};
          cnt = cnt + 2'd1;
        end
        CH_RBRACE: begin
          b.tok[cnt] = '{1'b0, 16'd1, p, jts_pkg::KIND_OBJ_CLOSE};
          cnt = cnt + 2'd1;
        end
        CH_LBRACK: begin
          b.tok[cnt] = '{1'b0, 16'd1, p, jts_pkg::KIND_ARR_OPEN};
          cnt = cnt + 2'd1;
        end
        CH_RBRACK: begin
          b.tok[cnt] = '{1'b0, 16'd1, p, jts_pkg::KIND_ARR_CLOSE};
          cnt = cnt + 2'd1;
        end
        CH_DQUOTE, CH_SQUOTE: begin
          mode_next           = MODE_STRING;
          quote_char_next     = (text_byte == CH_SQUOTE);
          escape_pending_next = 1'b0;
          token_begin_next    = nxt;
        end
        CH_F_LO, CH_F_UP: begin
          b.tok[cnt] = '{1'b0, LEN_FALSE, p, jts_pkg::KIND_FALSE};
          cnt = cnt + 2'd1;
          mode_next = MODE_SKIP;
          skip_remaining_next = SKIP_FALSE;
        end
        CH_T_LO, CH_T_UP: begin
          b.tok[cnt] = '{1'b0, LEN_SHORT, p, jts_pkg::KIND_TRUE};
          cnt = cnt + 2'd1;
          mode_next = MODE_SKIP;
          skip_remaining_next = SKIP_SHORT;
        end
        CH_N_LO, CH_N_UP: begin
          b.tok[cnt] = '{1'b0, LEN_SHORT, p, jts_pkg::KIND_NULL};
          cnt = cnt + 2'd1;
          mode_next = MODE_SKIP;
          skip_remaining_next = SKIP_SHORT;
        end
        default: begin
          if (is_number_start(text_byte)) begin
            mode_next        = MODE_NUMBER;
            token_begin_next = p;
          end else begin
            b.tok[cnt] = '{1'b0, 16'd1, p, jts_pkg::KIND_INVALID};
            cnt = cnt + 2'd1;
          end
        end
      endcase
    end

    // Final byte: close any open string or number, add the end token, start over.
    if (end_of_text) begin
      if (mode_next == MODE_STRING) begin
        b.tok[cnt] = '{1'b0, nxt - token_begin_next, token_begin_next, jts_pkg::KIND_STRING};
        cnt = cnt + 2'd1;
      end else if (mode_next == MODE_NUMBER) begin
        b.tok[cnt] = '{1'b0, nxt - token_begin_next, token_begin_next, jts_pkg::KIND_NUMBER};
        cnt = cnt + 2'd1;
      end
      b.tok[cnt] = '{1'b1, 16'd0, nxt, jts_pkg::KIND_END};
      cnt = cnt + 2'd1;
      mode_next           = MODE_IDLE;
      quote_char_next     = 1'b0;
      escape_pending_next = 1'b0;
      skip_remaining_next = '0;
      token_begin_next    = '0;
      byte_offset_next    = '0;
    end

    b.count = cnt;
    bundle  = b;
    push    = accept && (cnt != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      quote_char     <= 1'b0;
      escape_pending <= 1'b0;
      skip_remaining <= '0;
      token_begin    <= '0;
      byte_offset    <= '0;
    end else if (accept) begin
      mode           <= mode_next;
      quote_char     <= quote_char_next;
      escape_pending <= escape_pending_next;
      skip_remaining <= skip_remaining_next;
      token_begin    <= token_begin_next;
      byte_offset    <= byte_offset_next;
    end
  end

endmodule

// ===== src/jts_queue.sv =====
// Small register queue of token bundles between the scanner and the serializer.
module jts_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jts_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output jts_pkg::bundle_t head
);

  jts_pkg::bundle_t entries [jts_pkg::QUEUE_DEPTH];
  logic [jts_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [jts_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [jts_pkg::QUEUE_AW:0]   fill;

  assign full      = (fill == (jts_pkg::QUEUE_AW + 1)'(jts_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/jts_back.sv =====
// Token serializer: unpacks one bundle at a time into single output words.
module jts_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  jts_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output jts_pkg::token_t  out_token
);

  jts_pkg::bundle_t             cur;
  logic                         cur_valid;
  logic [jts_pkg::COUNT_W-1:0]  idx;
  logic                         done;
  logic                         take;

  assign done      = cur_valid && out_ready && (idx == cur.count - 2'd1);
  assign take      = !cur_valid || done;
  assign q_pop     = take && q_valid;
  assign out_valid = cur_valid;
  assign out_token = cur.tok[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      cur_valid <= q_valid;
      idx       <= '0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

endmodule

// ===== src/json_token_scanner_unit.sv =====
// Top level of the JSON token scanner: byte stream in, token stream out.
// An accepted byte's bundle is written into the queue, then loaded into the serializer's
// output register once the serializer is free; that register drives its first token word.
// Throughput: one byte per cycle while the queue has room; one token word leaves per cycle
// while m_axis_tready is high, so a byte with two or three tokens holds the serializer
// longer. The four-entry queue absorbs short bursts; s_axis_tready drops only when it fills.
// Reset (rst, synchronous, active high) returns the lexer to idle at offset 0
// and empties the queue and the output register.
module json_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
                                      // [35:20] token_length, [39:36] zero
  output logic        m_axis_tlast    // last_of_text
);

  // Front side: the scanner sees every accepted byte and pushes only bundles
  // that carry at least one token, so whitespace never occupies the queue.
  logic             accept;
  logic             push;
  jts_pkg::bundle_t bundle;

  // Queue side.
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  jts_pkg::bundle_t q_head;

  jts_pkg::token_t  token;

  // A byte can always be taken while the queue has room, even when the
  // serializer is stalled on the output side.
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  jts_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .push        (push),
    .bundle      (bundle)
  );

  jts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (bundle),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back side: the serializer holds one bundle and walks its tokens in order.
  jts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_token (token)
  );

  assign m_axis_tdata = {4'b0000, token.length, token.start, token.kind};
  assign m_axis_tlast = token.last;

endmodule
